// ===== sv/dbi9_pkg.sv =====
// shared types and constants for the nine-bit word packer
`default_nettype none
package dbi9_pkg;

	localparam int DBI9_QUEUE_DEPTH = 2;
	localparam int DBI9_CNT_W = 4;

	localparam logic [2:0] DBI9_GROUP_LAST_POS = 3'd7;
	localparam logic [7:0] DBI9_NOP_BYTE = 8'h00;
	localparam logic [DBI9_CNT_W-1:0] DBI9_CMD_POS = 4'd8;
	localparam logic [DBI9_CNT_W-1:0] DBI9_CMD_LAST_IDX = 4'd8;
	localparam logic [DBI9_CNT_W-1:0] DBI9_PAD_END = 4'd9;
	localparam logic [DBI9_CNT_W-1:0] DBI9_BITS_PER_BYTE = 4'd8;

	typedef struct packed {
		logic [DBI9_CNT_W-1:0] pos0;
		logic [7:0]            b0;
		logic [7:0]            b1;
		logic [DBI9_CNT_W-1:0] last_idx;
		logic                  err;
	} dbi9_desc_t;

endpackage
`default_nettype wire

// ===== sv/dbi_nine_bit_word_packer_unit.sv =====
// top level of the nine-bit word packer
//
// channel | handshake            | payload
// src     | src_valid, src_stall | data_byte, is_data, last
// dst     | dst_valid, dst_stall | out_byte, run_end, error
//
// one input item enters per cycle while the queue has room; the output side sends
// one byte per cycle while dst_stall is low, so an item becomes a burst of 1 to 9
// bytes: 1 for a plain data byte, 2 when it closes a group, up to 9 with padding
// or for a command. the byte-per-cycle output register sets the sustained rate.
// reset clears the packing state, empties the queue and clears the output valid flag.
// stalls on dst fill the queue of QUEUE_DEPTH bursts, then raise src_stall.
`default_nettype none
module dbi_nine_bit_word_packer_unit import dbi9_pkg::*; #(
	parameter int QUEUE_DEPTH = DBI9_QUEUE_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       src_valid,
	output logic            src_stall,
	input  wire logic [7:0] data_byte,
	input  wire logic       is_data,
	input  wire logic       last,
	output logic            dst_valid,
	input  wire logic       dst_stall,
	output logic [7:0]      out_byte,
	output logic            run_end,
	output logic            error
);

	logic       q_full;
	logic       q_push;
	logic       q_pop;
	logic       q_head_valid;
	dbi9_desc_t q_push_desc;
	dbi9_desc_t q_head_desc;

	dbi9_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.data_byte (data_byte),
		.is_data   (is_data),
		.last      (last),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_desc    (q_push_desc)
	);

	dbi9_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_desc  (q_push_desc),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head_desc  (q_head_desc)
	);

	dbi9_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_head_valid),
		.head_desc  (q_head_desc),
		.pop        (q_pop),
		.dst_valid  (dst_valid),
		.dst_stall  (dst_stall),
		.out_byte   (out_byte),
		.run_end    (run_end),
		.error      (error)
	);

endmodule
`default_nettype wire

// ===== sv/dbi9_front.sv =====
// front end: packs input words and turns each item into a byte burst descriptor
`default_nettype none
module dbi9_front import dbi9_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       src_valid,
	output logic            src_stall,
	input  wire logic [7:0] data_byte,
	input  wire logic       is_data,
	input  wire logic       last,
	input  wire logic       q_full,
	output logic            q_push,
	output dbi9_desc_t      q_desc
);

	logic [6:0] left_q;
	logic [2:0] pos_q;
	logic [6:0] left_d;
	logic [2:0] pos_d;

	logic [15:0] acc;
	logic [7:0]  shifted;
	logic [7:0]  mask;
	logic [7:0]  kept;
	logic [7:0]  pad;
	logic [DBI9_CNT_W-1:0] p1;

	assign src_stall = q_full;
	assign q_push    = src_valid && !q_full;

	assign acc     = {left_q, 1'b1, data_byte};
	assign p1      = {1'b0, pos_q} + 4'd1;
	assign shifted = 8'(acc >> p1);
	assign mask    = 8'((9'h001 << p1) - 9'h001);
	assign kept    = acc[7:0] & mask[7:0];
	assign pad     = kept << (DBI9_BITS_PER_BYTE - p1);

	always_comb begin
		q_desc = '0;
		left_d = left_q;
		pos_d  = pos_q;
		if (!is_data) begin
			q_desc.b1 = DBI9_NOP_BYTE;
			if (pos_q != 3'd0) begin
				q_desc.pos0     = '0;
				q_desc.b0       = DBI9_NOP_BYTE;
				q_desc.last_idx = '0;
				q_desc.err      = 1'b1;
			end else begin
				q_desc.pos0     = DBI9_CMD_POS;
				q_desc.b0       = data_byte;
				q_desc.last_idx = DBI9_CMD_LAST_IDX;
			end
		end else begin
			q_desc.pos0 = '0;
			q_desc.b0   = shifted[7:0];
			if (pos_q == DBI9_GROUP_LAST_POS) begin
				q_desc.b1       = kept;
				q_desc.last_idx = 4'd1;
				left_d          = '0;
				pos_d           = '0;
			end else if (last) begin
				q_desc.b1       = pad;
				q_desc.last_idx = DBI9_PAD_END - p1;
				left_d          = '0;
				pos_d           = '0;
			end else begin
				q_desc.b1       = DBI9_NOP_BYTE;
				q_desc.last_idx = '0;
				left_d          = kept[6:0];
				pos_d           = p1[2:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			pos_q  <= '0;
		end else if (q_push) begin
			left_q <= left_d;
			pos_q  <= pos_d;
		end
	end

endmodule
`default_nettype wire

// ===== sv/dbi9_queue.sv =====
// short descriptor queue between front and back
`default_nettype none
module dbi9_queue import dbi9_pkg::*; #(
	parameter int DEPTH = DBI9_QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire dbi9_desc_t  push_desc,
	output logic             full,
	input  wire logic        pop,
	output logic             head_valid,
	output dbi9_desc_t       head_desc
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	dbi9_desc_t   entry_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_desc  = entry_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== sv/dbi9_back.sv =====
// back end: plays each descriptor out as bytes through an output register
`default_nettype none
module dbi9_back import dbi9_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        head_valid,
	input  wire dbi9_desc_t  head_desc,
	output logic             pop,
	output logic             dst_valid,
	input  wire logic        dst_stall,
	output logic [7:0]       out_byte,
	output logic             run_end,
	output logic             error
);

	logic [DBI9_CNT_W-1:0] idx_q;
	logic                  valid_q;
	logic [7:0]            byte_q;
	logic                  end_q;
	logic                  err_q;
	logic                  load;
	logic                  fire;
	logic                  done;
	logic [7:0]            sel_byte;

	assign load = !valid_q || !dst_stall;
	assign fire = head_valid && load;
	assign done = (idx_q == head_desc.last_idx);
	assign pop  = fire && done;

	always_comb begin
		if (idx_q == head_desc.pos0) begin
			sel_byte = head_desc.b0;
		end else if (idx_q == head_desc.pos0 + 4'd1) begin
			sel_byte = head_desc.b1;
		end else begin
			sel_byte = DBI9_NOP_BYTE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= head_valid;
			end
			if (fire) begin
				idx_q <= done ? '0 : idx_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			byte_q <= sel_byte;
			end_q  <= done;
			err_q  <= head_desc.err;
		end
	end

	assign dst_valid = valid_q;
	assign out_byte  = byte_q;
	assign run_end   = end_q;
	assign error     = err_q;

endmodule
`default_nettype wire

// ===== sv/dbi9_checker.sv =====
// port-level checks for the nine-bit word packer and their bind
`default_nettype none
module dbi9_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       src_valid,
	input wire logic       src_stall,
	input wire logic [7:0] data_byte,
	input wire logic       is_data,
	input wire logic       last,
	input wire logic       dst_valid,
	input wire logic       dst_stall,
	input wire logic [7:0] out_byte,
	input wire logic       run_end,
	input wire logic       error
);

	logic unused_in;
	assign unused_in = src_valid ^ src_stall ^ (^data_byte) ^ is_data ^ last;

	a_reset_idle: assert property (@(posedge clk) !arst_n |=> !dst_valid)
		else $error("output valid during reset");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_stall |=> dst_valid && $stable(out_byte)
			&& $stable(run_end) && $stable(error))
		else $error("stalled output item changed");

	a_err_ends: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && error |-> run_end)
		else $error("error item does not end its burst");

	a_err_nop: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && error |-> out_byte == 8'h00)
		else $error("error item carries a nonzero byte");

endmodule

bind dbi_nine_bit_word_packer_unit dbi9_checker u_dbi9_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.src_valid (src_valid),
	.src_stall (src_stall),
	.data_byte (data_byte),
	.is_data   (is_data),
	.last      (last),
	.dst_valid (dst_valid),
	.dst_stall (dst_stall),
	.out_byte  (out_byte),
	.run_end   (run_end),
	.error     (error)
);
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// testbench for the nine-bit word packer: directed and random items checked against a predictor
`timescale 1ns / 1ps
module testbench;
	import dbi9_pkg::*;

	localparam logic FLAG_DATA = 1'b1;
	localparam logic FLAG_CMD = 1'b0;
	localparam int GROUP_WORDS = 8;
	localparam int MAX_WAIT = 6;
	localparam int RANDOM_ITEMS = 350;
	localparam int IDLE_LIMIT = 400;
	localparam int DRAIN_CYCLES = 20;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_end;
		logic       error;
	} link_byte_t;

	class word_pack_tracker;
		link_byte_t pending_bytes[$];
		logic [6:0] leftover;
		logic [2:0] group_pos;
		int mismatches;

		function new();
			leftover = '0;
			group_pos = '0;
			mismatches = 0;
		endfunction

		task report_mismatch(string msg);
			$display("mismatch: %s", msg);
			mismatches++;
		endtask

		// works out the link bytes caused by one accepted word
		function void note_word(logic [7:0] db, logic dc, logic lst);
			link_byte_t burst[$];
			logic [15:0] acc;
			logic [15:0] rem;
			int p;
			p = group_pos;
			if (dc == FLAG_CMD) begin
				if (p != 0) begin
					burst.push_back('{DBI9_NOP_BYTE, 1'b0, 1'b1});
				end else begin
					repeat (GROUP_WORDS) burst.push_back('{DBI9_NOP_BYTE, 1'b0, 1'b0});
					burst.push_back('{db, 1'b0, 1'b0});
				end
			end else begin
				acc = {leftover, 1'b1, db};
				burst.push_back('{8'(acc >> (p + 1)), 1'b0, 1'b0});
				rem = acc & ((16'd1 << (p + 1)) - 16'd1);
				p++;
				if (p == GROUP_WORDS) begin
					burst.push_back('{rem[7:0], 1'b0, 1'b0});
					rem = '0;
					p = 0;
				end
				if (lst && p != 0) begin
					burst.push_back('{8'(rem << (GROUP_WORDS - p)), 1'b0, 1'b0});
					for (int i = p; i < GROUP_WORDS; i++)
						burst.push_back('{DBI9_NOP_BYTE, 1'b0, 1'b0});
					rem = '0;
					p = 0;
				end
				leftover = rem[6:0];
				group_pos = p[2:0];
			end
			burst[burst.size() - 1].run_end = 1'b1;
			foreach (burst[i]) pending_bytes.push_back(burst[i]);
		endfunction

		task check_byte(logic [7:0] ob, logic re, logic er);
			link_byte_t want;
			if (pending_bytes.size() == 0) begin
				report_mismatch($sformatf("unexpected byte %02h run_end %b error %b", ob, re, er));
				return;
			end
			want = pending_bytes.pop_front();
			if (ob !== want.out_byte)
				report_mismatch($sformatf("out_byte %02h, want %02h", ob, want.out_byte));
			if (re !== want.run_end)
				report_mismatch($sformatf("run_end %b, want %b", re, want.run_end));
			if (er !== want.error)
				report_mismatch($sformatf("error %b, want %b", er, want.error));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic src_valid = 1'b0;
	logic src_stall;
	logic [7:0] data_byte = '0;
	logic is_data = 1'b0;
	logic last = 1'b0;
	logic dst_valid;
	logic dst_stall = 1'b0;
	logic [7:0] out_byte;
	logic run_end;
	logic error;

	word_pack_tracker tracker = new();
	int items_sent = 0;
	int idle_cycles = 0;
	bit src_no_gap = 1'b0;
	bit dst_no_stall = 1'b0;

	dbi_nine_bit_word_packer_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.data_byte(data_byte),
		.is_data(is_data),
		.last(last),
		.dst_valid(dst_valid),
		.dst_stall(dst_stall),
		.out_byte(out_byte),
		.run_end(run_end),
		.error(error)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && dst_valid && !dst_stall)
			tracker.check_byte(out_byte, run_end, error);
	end

	always @(posedge clk) begin
		if ((src_valid && !src_stall) || (dst_valid && !dst_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT) @(posedge clk);
		$display("DONE: errors detected");
		$finish;
	end

	// sink side: random stall before each item, with calm stretches
	initial begin
		int n;
		int taken;
		taken = 0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (taken % 32 == 0)
				dst_no_stall = ($urandom_range(0, 3) == 0);
			n = dst_no_stall ? 0 : $urandom_range(0, MAX_WAIT);
			if (n > 0) begin
				dst_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			dst_stall <= 1'b0;
			do @(posedge clk); while (!dst_valid);
			taken++;
		end
	end

	task automatic send_item(input logic [7:0] b, input logic d, input logic l);
		int gap;
		gap = src_no_gap ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap > 0) begin
			src_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		src_valid <= 1'b1;
		data_byte <= b;
		is_data <= d;
		last <= l;
		do @(posedge clk); while (src_stall);
		tracker.note_word(b, d, l);
		items_sent++;
	endtask

	task automatic send_run(input int len, input bit close);
		for (int i = 0; i < len; i++)
			send_item(8'($urandom), FLAG_DATA, close && (i == len - 1));
	endtask

	initial begin
		int kind;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		send_item(8'h00, FLAG_CMD, 1'b0);
		send_item(8'hFF, FLAG_CMD, 1'b1);
		send_item(8'hFF, FLAG_DATA, 1'b1);
		send_item(8'h00, FLAG_DATA, 1'b0);
		send_item(8'hA5, FLAG_DATA, 1'b0);
		send_item(8'h5A, FLAG_DATA, 1'b1);
		for (int i = 0; i < GROUP_WORDS; i++)
			send_item(8'(i * 8'h21 + 8'h0F), FLAG_DATA, i == GROUP_WORDS - 1);
		send_item(8'h3C, FLAG_DATA, 1'b0);
		send_item(8'h2C, FLAG_CMD, 1'b0);
		send_item(8'hC3, FLAG_DATA, 1'b1);
		for (int i = 0; i < GROUP_WORDS - 1; i++)
			send_item(8'(8'hF0 - i * 8'h13), FLAG_DATA, i == GROUP_WORDS - 2);

		while (items_sent < RANDOM_ITEMS) begin
			src_no_gap = ($urandom_range(0, 4) == 0);
			kind = $urandom_range(0, 9);
			if (kind <= 5) begin
				send_run($urandom_range(1, 20), 1'b1);
			end else if (kind <= 7) begin
				send_item(8'($urandom), FLAG_CMD, 1'($urandom));
			end else if (kind == 8) begin
				repeat ($urandom_range(1, 6))
					send_item(8'($urandom), 1'($urandom), 1'($urandom));
			end else begin
				send_run($urandom_range(1, 7), 1'b0);
				send_item(8'($urandom), FLAG_CMD, 1'($urandom));
				send_run($urandom_range(1, 12), 1'b1);
			end
		end
		src_valid <= 1'b0;

		while (tracker.pending_bytes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

// ===== sim.f =====
sv/dbi9_pkg.sv
sv/dbi9_front.sv
sv/dbi9_queue.sv
sv/dbi9_back.sv
sv/dbi_nine_bit_word_packer_unit.sv
sv/dbi9_checker.sv
tb/sv/testbench.sv
